// ----- rtl/mhst_pkg.sv -----
`timescale 1ns / 1ps

package mhst_pkg;

    // Table geometry.
    localparam int SQUARES     = 128;
    localparam int SQ_W        = 7;
    localparam int ENTRIES     = SQUARES * SQUARES;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int SQ_CMP_W    = SQ_W + 2;
    localparam int DECAY_SHIFT = 8;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
    localparam logic [SQ_CMP_W-1:0] SQ_LIMIT = SQ_CMP_W'(SQUARES);

    // Score values.
    localparam int VALUE_W = 32;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam int ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_DECAY = 2'd3
    } mhst_action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch an add or read item and start its table read
        logic update;       // finish an add or read: write back and load the result
        logic sweep_start;  // start a pass over every table entry
        logic sweep_clear;  // the pass writes zero instead of the decayed value
        logic bulk_resp;    // load a zero result for clear or decay
    } mhst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // the result register can take a new result this cycle
        logic sweep_done;   // the last entry of the pass is written this cycle
    } mhst_stat_t;

endpackage

// ----- rtl/mhst_item_if.sv -----
`timescale 1ns / 1ps

interface mhst_item_if
    import mhst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    mhst_action_t              action;
    logic [SQ_W-1:0]           from_square;
    logic [SQ_W-1:0]           to_square;
    logic signed [VALUE_W-1:0] amount;

    modport source (output valid, action, from_square, to_square, amount, input ready);
    modport sink   (input valid, action, from_square, to_square, amount, output ready);
endinterface

// ----- rtl/mhst_result_if.sv -----
`timescale 1ns / 1ps

interface mhst_result_if
    import mhst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

// ----- rtl/mhst_ctrl.sv -----
`timescale 1ns / 1ps

module mhst_ctrl
    import mhst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  mhst_action_t item_action,
    output logic         item_ready,
    input  mhst_stat_t   stat,
    output mhst_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_INIT      = 5'b00001,
        S_IDLE      = 5'b00010,
        S_UPDATE    = 5'b00100,
        S_SWEEP     = 5'b01000,
        S_BULK_RESP = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                // The datapath runs its clearing pass straight out of reset.
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item_action) inside
                        ACT_ADD, ACT_READ:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_UPDATE;
                        end
                        default:
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_clear = (item_action == ACT_CLEAR);
                            state_next      = S_SWEEP;
                        end
                    endcase
                end
            end
            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_BULK_RESP;
                end
            end
            S_BULK_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.bulk_resp = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/mhst_dp.sv -----
`timescale 1ns / 1ps

module mhst_dp
    import mhst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mhst_cmd_t                 cmd,
    output mhst_stat_t                stat,
    input  mhst_action_t              action,
    input  logic [SQ_W-1:0]           from_square,
    input  logic [SQ_W-1:0]           to_square,
    input  logic signed [VALUE_W-1:0] amount,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] value,
    output logic                      saturated
);

    logic signed [VALUE_W-1:0] score_mem [ENTRIES];

    // Item registers.
    mhst_action_t              action_reg;
    logic signed [VALUE_W-1:0] amount_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      in_range_reg;

    // Sweep pipeline: read stage, then write stage in the cycle after it.
    logic                      rd_active_reg;
    logic [ADDR_W-1:0]         rd_cnt_reg;
    logic                      wr_valid_reg;
    logic [ADDR_W-1:0]         wr_addr_reg;
    logic                      clear_mode_reg;

    logic signed [VALUE_W-1:0] rd_data_reg;

    // Result register.
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      sat_reg;

    logic [ADDR_W-1:0]         item_addr;
    logic                      item_in_range;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      rd_en;
    logic signed [VALUE_W:0]   sum_wide;
    logic                      overflow;
    logic signed [VALUE_W-1:0] sum_sat;
    logic signed [VALUE_W-1:0] decay_value;
    logic signed [VALUE_W-1:0] sweep_wdata;
    logic                      item_write;
    logic signed [VALUE_W-1:0] result_value;
    logic                      result_sat;

    assign item_addr = ADDR_W'(ADDR_W'(from_square) * ADDR_W'(SQUARES)) + ADDR_W'(to_square);
    assign item_in_range = (SQ_CMP_W'(from_square) < SQ_LIMIT)
                        && (SQ_CMP_W'(to_square) < SQ_LIMIT);

    assign rd_addr = rd_active_reg ? rd_cnt_reg : item_addr;
    assign rd_en   = rd_active_reg || cmd.capture;

    // Saturating add on the entry read for the current item.
    assign sum_wide = {rd_data_reg[VALUE_W-1], rd_data_reg} + {amount_reg[VALUE_W-1], amount_reg};
    assign overflow = (sum_wide[VALUE_W] != sum_wide[VALUE_W-1]);
    assign sum_sat  = overflow ? (sum_wide[VALUE_W] ? VALUE_MIN : VALUE_MAX)
                               : sum_wide[VALUE_W-1:0];

    // The shift is kept on its own so that it stays arithmetic.
    assign decay_value = rd_data_reg >>> DECAY_SHIFT;
    assign sweep_wdata = clear_mode_reg ? '0 : decay_value;

    assign item_write = cmd.update && in_range_reg && (action_reg == ACT_ADD);

    always_comb
    begin
        result_value = '0;
        result_sat   = 1'b0;
        if (in_range_reg)
        begin
            if (action_reg == ACT_ADD)
            begin
                result_value = sum_sat;
                result_sat   = overflow;
            end
            else
            begin
                result_value = rd_data_reg;
            end
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.sweep_done = wr_valid_reg && (wr_addr_reg == LAST_ADDR);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= score_mem[rd_addr];
        end
        if (wr_valid_reg)
        begin
            score_mem[wr_addr_reg] <= sweep_wdata;
        end
        else if (item_write)
        begin
            score_mem[addr_reg] <= sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            amount_reg   <= amount;
            addr_reg     <= item_addr;
            in_range_reg <= item_in_range;
        end
        if (cmd.update || cmd.bulk_resp)
        begin
            value_reg <= cmd.update ? result_value : '0;
            sat_reg   <= cmd.update && result_sat;
        end
        wr_addr_reg <= rd_cnt_reg;
    end

    // The sweep starts active in clear mode so that reset runs a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg  <= 1'b1;
            rd_cnt_reg     <= '0;
            wr_valid_reg   <= 1'b0;
            clear_mode_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= rd_active_reg;
            if (cmd.sweep_start)
            begin
                rd_active_reg  <= 1'b1;
                rd_cnt_reg     <= '0;
                clear_mode_reg <= cmd.sweep_clear;
            end
            else if (rd_active_reg)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == LAST_ADDR)
                begin
                    rd_active_reg <= 1'b0;
                end
            end
            if (cmd.update || cmd.bulk_resp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

// ----- rtl/move_history_score_table.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Fields                                        | Meaning
// ---------+-----+-----------------------------------------------+------------------------------
// item     | in  | action, from_square, to_square, amount        | one action on the score table
// result   | out | value, saturated                              | one answer per item
//
// An add or a read first reads the entry from the single-port-read, single-port-write
// table memory into a register, then saturates, writes back and loads the result once
// the result register is free.
// Clear and decay walk all ENTRIES entries through that one read and one write port,
// one entry a cycle. After reset the block runs a clearing pass with item.ready low.
// A held result does not stop the next item from being accepted; the block stalls only
// when a new result is ready while the previous one has not yet been taken.

module move_history_score_table
    import mhst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mhst_item_if.sink     item,
    mhst_result_if.source result
);

    mhst_cmd_t  cmd;
    mhst_stat_t stat;

    // The controller sequences each transaction: item capture, the table read, the
    // write back, and the bulk sweeps.
    mhst_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // The datapath holds the table memory, the saturating adder, the decay shifter,
    // the sweep counters and the result register.
    mhst_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (item.action),
        .from_square (item.from_square),
        .to_square   (item.to_square),
        .amount      (item.amount),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .value       (result.value),
        .saturated   (result.saturated)
    );

endmodule

// ----- rtl/mhst_checker.sv -----
`timescale 1ns / 1ps

module mhst_checker
    import mhst_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_valid,
    input logic                      item_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic signed [VALUE_W-1:0] result_value,
    input logic                      result_saturated
);

    // A waiting result keeps its valid and its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value)
                                          && $stable(result_saturated))
        else $error("result changed while stalled");

    // Items are worked on one at a time, so the block is busy right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while the previous one is still in work");

    // A clipped add always shows one of the signed limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_saturated |-> result_value == VALUE_MAX
                                             || result_value == VALUE_MIN)
        else $error("saturated result is not at a limit");

    // No result can appear in the cycle right after an item transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
        else $error("result appeared too early");

endmodule

bind move_history_score_table mhst_checker u_mhst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_value     (result.value),
    .result_saturated (result.saturated)
);
